// ===== src/lztd_pkg.sv =====
package lztd_pkg;

	localparam int COUNT_W = 25;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 25'h1FFFFFF;
	localparam logic [COUNT_W-1:0] LIMIT_RESET = 25'h40000;

	localparam int DIST_W = 13;
	localparam int LEN_W = 4;
	localparam int LITS_W = 5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_REF = 2'd1;
	localparam logic [1:0] ERR_LIMIT = 2'd2;

	typedef enum logic [1:0] {
		PH_TOKEN,
		PH_OFFSET,
		PH_LITERAL
	} phase_t;

	typedef enum logic [1:0] {
		CMD_LIT,
		CMD_MATCH,
		CMD_STATUS
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] lit;
		logic [DIST_W-1:0] copy_dist;
		logic [LEN_W-1:0] len_m1;
		logic [1:0] code;
		logic last;
	} cmd_t;

endpackage

// ===== src/lztd_ram.sv =====
module lztd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read returns the old contents on a same-address write.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/lztd_front.sv =====
module lztd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	input  logic                          cfg_wen,
	input  logic [lztd_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic                          q_full,
	output logic                          push,
	output lztd_pkg::cmd_t                cmd
);

	lztd_pkg::phase_t phase_q, phase_d;
	logic [lztd_pkg::COUNT_W-1:0] count_q, count_d;
	logic [lztd_pkg::COUNT_W-1:0] limit_q;
	logic [lztd_pkg::LITS_W-1:0] lits_q, lits_d, lits_dec;
	logic [7:0] token_q, token_d;
	logic err_q, err_d;

	logic accept;
	logic [lztd_pkg::DIST_W-1:0] copy_dist;
	logic [lztd_pkg::LITS_W-1:0] add_amt;
	logic [lztd_pkg::COUNT_W:0] count_sum;
	logic [lztd_pkg::COUNT_W-1:0] count_sat;
	logic ref_err, limit_err;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;

	assign copy_dist = lztd_pkg::DIST_W'({token_q[7:4], in_byte}) + lztd_pkg::DIST_W'(1);
	assign ref_err = lztd_pkg::COUNT_W'(copy_dist) > count_q;
	assign limit_err = count_q > limit_q;

	// One adder serves both the match length and the single literal.
	assign add_amt = (phase_q == lztd_pkg::PH_OFFSET) ?
		(lztd_pkg::LITS_W'(token_q[3:0]) + lztd_pkg::LITS_W'(1)) : lztd_pkg::LITS_W'(1);
	assign count_sum = {1'b0, count_q} + (lztd_pkg::COUNT_W+1)'(add_amt);
	assign count_sat = count_sum[lztd_pkg::COUNT_W] ? lztd_pkg::COUNT_MAX :
		count_sum[lztd_pkg::COUNT_W-1:0];
	assign lits_dec = (lits_q != '0) ? lits_q - lztd_pkg::LITS_W'(1) : '0;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		lits_d = lits_q;
		token_d = token_q;
		err_d = err_q;
		if (accept) begin
			if (!err_q) begin
				case (phase_q)
					lztd_pkg::PH_OFFSET: begin
						phase_d = lztd_pkg::PH_TOKEN;
						if (ref_err) begin
							err_d = 1'b1;
						end else begin
							count_d = count_sat;
						end
					end
					lztd_pkg::PH_LITERAL: begin
						count_d = count_sat;
						lits_d = lits_dec;
						if (lits_dec == '0) begin
							phase_d = lztd_pkg::PH_TOKEN;
						end
					end
					default: begin
						phase_d = lztd_pkg::PH_TOKEN;
						if (limit_err) begin
							err_d = 1'b1;
						end else if (in_byte[3:0] != 4'd0) begin
							token_d = in_byte;
							phase_d = lztd_pkg::PH_OFFSET;
						end else begin
							lits_d = lztd_pkg::LITS_W'(in_byte[7:4]) + lztd_pkg::LITS_W'(1);
							phase_d = lztd_pkg::PH_LITERAL;
						end
					end
				endcase
			end
			if (in_last) begin
				phase_d = lztd_pkg::PH_TOKEN;
				count_d = '0;
				lits_d = '0;
				token_d = '0;
				err_d = 1'b0;
			end
		end
	end

	always_comb begin
		push = 1'b0;
		cmd.kind = lztd_pkg::CMD_STATUS;
		cmd.lit = '0;
		cmd.copy_dist = copy_dist;
		cmd.len_m1 = token_q[3:0];
		cmd.code = lztd_pkg::ERR_NONE;
		cmd.last = in_last;
		if (accept) begin
			if (!err_q) begin
				case (phase_q)
					lztd_pkg::PH_OFFSET: begin
						push = 1'b1;
						if (ref_err) begin
							cmd.code = lztd_pkg::ERR_REF;
						end else begin
							cmd.kind = lztd_pkg::CMD_MATCH;
						end
					end
					lztd_pkg::PH_LITERAL: begin
						push = 1'b1;
						cmd.kind = lztd_pkg::CMD_LIT;
						cmd.lit = in_byte;
					end
					default: begin
						if (limit_err) begin
							push = 1'b1;
							cmd.code = lztd_pkg::ERR_LIMIT;
						end
					end
				endcase
			end
			if (in_last) begin
				push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lztd_pkg::PH_TOKEN;
			count_q <= '0;
			lits_q <= '0;
			token_q <= '0;
			err_q <= 1'b0;
			limit_q <= lztd_pkg::LIMIT_RESET;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			lits_q <= lits_d;
			token_q <= token_d;
			err_q <= err_d;
			if (cfg_wen) begin
				limit_q <= cfg_wdata;
			end
		end
	end

endmodule

// ===== src/lztd_queue.sv =====
module lztd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lztd_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output lztd_pkg::cmd_t head
);

	lztd_pkg::cmd_t entries [lztd_pkg::QUEUE_DEPTH];
	logic [lztd_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [lztd_pkg::QPTR_W:0] fill_q;

	assign full = fill_q == (lztd_pkg::QPTR_W+1)'(lztd_pkg::QUEUE_DEPTH);
	assign head_valid = fill_q != '0;
	assign head = entries[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + lztd_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lztd_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (lztd_pkg::QPTR_W+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (lztd_pkg::QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ===== src/lztd_back.sv =====
module lztd_back #(
	parameter int WINDOW_DEPTH = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  lztd_pkg::cmd_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     data_byte,
	output logic           data_valid,
	output logic           run_last,
	output logic           blob_end,
	output logic [1:0]     error_code
);

	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [lztd_pkg::COUNT_W-1:0] cnt_q;
	logic [lztd_pkg::COUNT_W:0] cnt_sum;
	logic [lztd_pkg::COUNT_W-1:0] cnt_sat;
	logic [lztd_pkg::LEN_W-1:0] idx_q;

	logic out_adv, s1_free, issue, is_match, is_status, cmd_done;
	logic [AW:0] rdiff;
	logic [AW-1:0] raddr;
	logic re, we;
	logic [7:0] rdata;

	logic s1_valid_q;
	logic from_ram_s1, dvalid_s1, run_last_s1, blob_end_s1;
	logic [7:0] lit_s1;
	logic [1:0] code_s1;
	logic [AW-1:0] waddr_s1;
	logic [7:0] byte_s1;

	logic byp_q;
	logic [7:0] byp_data_q;

	assign out_adv = !out_valid || !out_stall;
	assign s1_free = !s1_valid_q || out_adv;
	assign issue = head_valid && s1_free;
	assign is_match = head.kind == lztd_pkg::CMD_MATCH;
	assign is_status = head.kind == lztd_pkg::CMD_STATUS;
	assign cmd_done = !is_match || (idx_q == head.len_m1);
	assign pop = issue && cmd_done;

	assign cnt_sum = {1'b0, cnt_q} + (lztd_pkg::COUNT_W+1)'(1);
	assign cnt_sat = cnt_sum[lztd_pkg::COUNT_W] ? lztd_pkg::COUNT_MAX :
		cnt_sum[lztd_pkg::COUNT_W-1:0];

	// Source address of the next copied byte; the distance never exceeds the
	// count, so only the low address bits matter.
	assign rdiff = {1'b0, cnt_q[AW-1:0]} - (AW+1)'(head.copy_dist);
	assign raddr = rdiff[AW-1:0];
	assign re = issue && is_match;

	assign byte_s1 = from_ram_s1 ? (byp_q ? byp_data_q : rdata) : lit_s1;
	assign we = s1_valid_q && out_adv && dvalid_s1;

	lztd_ram #(
		.WIDTH(8),
		.DEPTH(1 << AW)
	) u_window (
		.clk   (clk),
		.we    (we),
		.waddr (waddr_s1),
		.wdata (byte_s1),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Distance-one copies read the byte being written in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (re) begin
			byp_q <= we && (waddr_s1 == raddr);
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			byp_data_q <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			s1_valid_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (issue) begin
				if (pop && head.last) begin
					cnt_q <= '0;
				end else if (!is_status) begin
					cnt_q <= cnt_sat;
				end
				if (is_match) begin
					idx_q <= cmd_done ? '0 : idx_q + lztd_pkg::LEN_W'(1);
				end
			end
			if (issue) begin
				s1_valid_q <= 1'b1;
			end else if (out_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (out_adv) begin
				out_valid <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			from_ram_s1 <= is_match;
			lit_s1 <= (head.kind == lztd_pkg::CMD_LIT) ? head.lit : 8'd0;
			dvalid_s1 <= !is_status;
			run_last_s1 <= cmd_done;
			blob_end_s1 <= cmd_done && head.last;
			code_s1 <= is_status ? head.code : lztd_pkg::ERR_NONE;
			waddr_s1 <= cnt_q[AW-1:0];
		end
		if (s1_valid_q && out_adv) begin
			data_byte <= byte_s1;
			data_valid <= dvalid_s1;
			run_last <= run_last_s1;
			blob_end <= blob_end_s1;
			error_code <= code_s1;
		end
	end

endmodule

// ===== src/lz_token_decompressor_core.sv =====
// Path: a result request travels from the accepted input byte that causes it through the
// command queue, the stage-one registers and the output registers to the output.
// Throughput: one result per cycle from the back end unless the output stalls; a match
// token emits up to sixteen bytes, so input bytes are taken at one per cycle until the four-entry queue fills.
// Reset: parser, queue and output control clear at once; output_limit resets to 262144;
// the history window is not cleared, since every read hits a byte written in this blob.
module lz_token_decompressor_core #(
	parameter int WINDOW_DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Compressed input requests.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	input  logic                          in_last,
	// Output limit register write.
	input  logic                          cfg_wen,
	input  logic [lztd_pkg::COUNT_W-1:0]  cfg_wdata,
	// Decompressed result requests.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    data_byte,
	output logic                          data_valid,
	output logic                          run_last,
	output logic                          blob_end,
	output logic [1:0]                    error_code
);

	// The front end parses tokens, offsets and literals, keeps its own copy of the
	// output count, and makes every error decision up front. It hands one command
	// per result-producing input byte to a small queue.
	logic q_push, q_full, q_pop, q_valid;
	lztd_pkg::cmd_t q_in_cmd, q_head;

	lztd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (q_push),
		.cmd       (q_in_cmd)
	);

	lztd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_in_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// The back end expands commands into bytes, one per cycle while the output is not
	// stalled, through the history window memory, with a bypass for copies at distance one.
	lztd_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.data_valid (data_valid),
		.run_last   (run_last),
		.blob_end   (blob_end),
		.error_code (error_code)
	);

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command queue written while full");

	a_blob_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && blob_end |-> run_last)
		else $error("blob end without run end");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> data_byte == 8'd0)
		else $error("status result carries data");

	a_error_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != lztd_pkg::ERR_NONE |-> !data_valid && run_last)
		else $error("error result is not a status-only run end");
`endif

endmodule
